@@ hw/rtl/assert_macros.svh @@
// assertion macros for the header parser checker
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked in the cycle after its trigger
`define ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) trig |=> prop) else $error(msg);

`endif

@@ hw/rtl/ash_pkg.sv @@
// shared types and constants of the aiff stream header parser
// no dependencies
package ash_pkg;

    typedef enum logic [3:0] {
        PH_HDR    = 4'd0,
        PH_SEEKC  = 4'd1,
        PH_COMM   = 4'd2,
        PH_SKIPC  = 4'd3,
        PH_SKIPAC = 4'd4,
        PH_SEEKS  = 4'd5,
        PH_SKIPS  = 4'd6,
        PH_SSNDH  = 4'd7,
        PH_OFFS   = 4'd8,
        PH_DATA   = 4'd9,
        PH_DONE   = 4'd10,
        PH_ERR    = 4'd11
    } ash_phase_t;

    typedef enum logic [2:0] {
        EV_HEADER = 3'd0,
        EV_READY  = 3'd1,
        EV_SAMPLE = 3'd2,
        EV_ERROR  = 3'd3,
        EV_IGNORE = 3'd4
    } ash_event_t;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_BAD_FORM  = 4'd1,
        ERR_BAD_TYPE  = 4'd2,
        ERR_NO_COMM   = 4'd3,
        ERR_ZERO_CHAN = 4'd4,
        ERR_ZERO_FRM  = 4'd5,
        ERR_ZERO_SIZE = 4'd6,
        ERR_ZERO_RATE = 4'd7,
        ERR_NO_SSND   = 4'd8
    } ash_error_t;

    localparam logic [31:0] ID_FORM = 32'h464F524D;
    localparam logic [31:0] ID_AIFF = 32'h41494646;
    localparam logic [31:0] ID_AIFC = 32'h41494643;
    localparam logic [31:0] ID_COMM = 32'h434F4D4D;
    localparam logic [31:0] ID_SSND = 32'h53534E44;

    localparam logic [14:0] EXP_SPECIAL = 15'h7FFF;
    // exponent bias plus mantissa fraction bits
    localparam logic [14:0] EXP_UNITY   = 15'd16446;
    localparam logic [31:0] COMM_USED_AIFF = 32'd18;
    localparam logic [31:0] COMM_USED_AIFC = 32'd22;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
    } ash_in_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  sample_byte;
        logic        frame_end;
        logic        last_sample;
        logic [3:0]  error_code;
        logic        is_aifc;
        logic [15:0] channel_count;
        logic [31:0] frame_count;
        logic [15:0] bits_per_sample;
        logic [63:0] rate_hz;
        logic [31:0] total_size;
    } ash_out_t;

endpackage

@@ hw/rtl/aiff_stream_header_parser.sv @@
// aiff / aifc header parser top level: byte stream in, one result per byte out
// depends on ash_pkg and ash_rate_conv
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------
//  input   | src_valid | src_stall | src_data (file byte, restart)
//  result  | res_valid | res_stall | res_data (event, fields)
//
// one byte per cycle while the input is not stalled, one result per byte; the result is registered
// and shows in the cycle after acceptance; all parsing work happens in the cycle of acceptance into the result register
// reset clears the parse state; restart on a byte clears it before the byte
// a stalled result holds; input stalls only while a result waits and is stalled
// frame size product is registered from the comm fields, long before data starts
module aiff_stream_header_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             src_valid,
    output logic             src_stall,
    input  ash_pkg::ash_in_t src_data,
    output logic             res_valid,
    input  logic             res_stall,
    output ash_pkg::ash_out_t res_data
);
    import ash_pkg::*;

    // parse state
    ash_phase_t  phase_reg, phase_next;
    logic [4:0]  idx_reg, idx_next;
    logic [63:0] shift_reg, shift_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] form_size_reg, form_size_next;
    logic [31:0] left_reg, left_next;
    logic        aifc_reg, aifc_next;
    logic        comm_found_reg, comm_found_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] frames_reg, frames_next;
    logic [15:0] size_reg, size_next;
    logic [63:0] rate_reg, rate_next;
    logic [31:0] bif_reg, bif_next;
    logic [31:0] done_reg, done_next;
    logic [3:0]  err_reg, err_next;
    logic [31:0] frame_bytes_reg;

    // result register
    logic        res_valid_reg, res_valid_next;
    ash_out_t    res_reg, res_next;

    logic        accept;
    logic [63:0] conv_rate;
    logic [31:0] lo32, hi32, pad, used;
    logic [4:0]  idx;
    ash_event_t  ev;
    logic [7:0]  sb;
    logic        fe, ls, comm_end;
    logic [16:0] size_round;
    logic [13:0] sample_bytes;

    assign src_stall = res_valid_reg & res_stall;
    assign accept    = src_valid & ~src_stall;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // sample size rounded up to whole bytes, one bit of headroom for the carry
    assign size_round   = {1'b0, size_reg} + 17'd7;
    assign sample_bytes = size_round[16:3];

    // rate_reg's low bits already hold the exponent word and the shift register holds the mantissa
    ash_rate_conv u_rate (
        .expw (rate_reg[15:0] & {16{~src_data.restart}}),
        .mant (shift_next),
        .rate (conv_rate)
    );

    always_comb
    begin
        // restart clears everything before the byte is taken
        phase_next      = src_data.restart ? PH_HDR : phase_reg;
        idx_next        = src_data.restart ? 5'd0   : idx_reg;
        shift_next      = src_data.restart ? 64'd0  : shift_reg;
        pos_next        = src_data.restart ? 32'd0  : pos_reg;
        form_size_next  = src_data.restart ? 32'd0  : form_size_reg;
        left_next       = src_data.restart ? 32'd0  : left_reg;
        aifc_next       = src_data.restart ? 1'b0   : aifc_reg;
        comm_found_next = src_data.restart ? 1'b0   : comm_found_reg;
        chan_next       = src_data.restart ? 16'd0  : chan_reg;
        frames_next     = src_data.restart ? 32'd0  : frames_reg;
        size_next       = src_data.restart ? 16'd0  : size_reg;
        rate_next       = src_data.restart ? 64'd0  : rate_reg;
        bif_next        = src_data.restart ? 32'd0  : bif_reg;
        done_next       = src_data.restart ? 32'd0  : done_reg;
        err_next        = src_data.restart ? 4'd0   : err_reg;

        ev       = EV_HEADER;
        sb       = 8'd0;
        fe       = 1'b0;
        ls       = 1'b0;
        idx      = idx_next;
        lo32     = 32'd0;
        hi32     = 32'd0;
        pad      = 32'd0;
        used     = 32'd0;
        comm_end = 1'b0;

        if ((phase_next == PH_DONE) || (phase_next == PH_ERR))
        begin
            ev = EV_IGNORE;
        end
        else
        begin
            pos_next   = pos_next + 32'd1;
            shift_next = {shift_next[55:0], src_data.in_byte};
            if (idx != 5'd31)
            begin
                idx_next = idx + 5'd1;
            end
            lo32 = shift_next[31:0];
            hi32 = shift_next[63:32];
            pad  = lo32 + {31'd0, lo32[0]};

            case (phase_next)
                PH_HDR:
                begin
                    if ((idx == 5'd3) && (lo32 != ID_FORM))
                    begin
                        ev = EV_ERROR; err_next = ERR_BAD_FORM; phase_next = PH_ERR;
                    end
                    else if (idx == 5'd7)
                    begin
                        form_size_next = (lo32 + 32'd8) + {31'd0, lo32[0]};
                    end
                    else if (idx == 5'd11)
                    begin
                        if ((lo32 != ID_AIFF) && (lo32 != ID_AIFC))
                        begin
                            ev = EV_ERROR; err_next = ERR_BAD_TYPE; phase_next = PH_ERR;
                        end
                        else
                        begin
                            aifc_next = (lo32 == ID_AIFC);
                            idx_next  = 5'd0;
                            if (pos_next == form_size_next)
                            begin
                                ev = EV_ERROR; err_next = ERR_NO_COMM; phase_next = PH_ERR;
                            end
                            else
                            begin
                                phase_next = PH_SEEKC;
                            end
                        end
                    end
                end
                PH_SEEKC, PH_SEEKS:
                begin
                    if (idx == 5'd7)
                    begin
                        idx_next = 5'd0;
                        if ((phase_next == PH_SEEKC) && (hi32 == ID_COMM))
                        begin
                            left_next = pad; phase_next = PH_COMM;
                        end
                        else if ((phase_next == PH_SEEKS) && (hi32 == ID_SSND))
                        begin
                            phase_next = PH_SSNDH;
                        end
                        else
                        begin
                            left_next = pad;
                            if (pad == 32'd0)
                            begin
                                if (pos_next == form_size_next)
                                begin
                                    ev = EV_ERROR;
                                    err_next = (phase_next == PH_SEEKC) ? ERR_NO_COMM
                                                                        : ERR_NO_SSND;
                                    phase_next = PH_ERR;
                                end
                            end
                            else
                            begin
                                phase_next = (phase_next == PH_SEEKC) ? PH_SKIPC : PH_SKIPS;
                            end
                        end
                    end
                end
                PH_COMM:
                begin
                    comm_end = 1'b1;
                    if (idx == 5'd1)
                    begin
                        chan_next = lo32[15:0];
                    end
                    else if (idx == 5'd5)
                    begin
                        frames_next = lo32;
                    end
                    else if (idx == 5'd7)
                    begin
                        size_next = lo32[15:0];
                    end
                    else if (idx == 5'd9)
                    begin
                        rate_next = {48'd0, lo32[15:0]};
                    end
                    else if (idx == 5'd17)
                    begin
                        // zero field checks in fixed priority
                        rate_next = conv_rate;
                        comm_end  = 1'b0;
                        ev        = EV_ERROR;
                        phase_next = PH_ERR;
                        if (chan_next == 16'd0)
                        begin
                            err_next = ERR_ZERO_CHAN;
                        end
                        else if (frames_next == 32'd0)
                        begin
                            err_next = ERR_ZERO_FRM;
                        end
                        else if (size_next == 16'd0)
                        begin
                            err_next = ERR_ZERO_SIZE;
                        end
                        else if (conv_rate == 64'd0)
                        begin
                            err_next = ERR_ZERO_RATE;
                        end
                        else
                        begin
                            ev         = EV_HEADER;
                            phase_next = PH_COMM;
                            comm_end   = 1'b1;
                        end
                    end
                    // end of the fields read from comm
                    if (comm_end && ((aifc_next && (idx == 5'd21)) ||
                                     (!aifc_next && (idx == 5'd17))))
                    begin
                        used = aifc_next ? COMM_USED_AIFC : COMM_USED_AIFF;
                        left_next = (left_next > used) ? (left_next - used) : 32'd0;
                        comm_found_next = 1'b1;
                        if (left_next == 32'd0)
                        begin
                            idx_next = 5'd0;
                            if (pos_next == form_size_next)
                            begin
                                ev = EV_ERROR; err_next = ERR_NO_SSND; phase_next = PH_ERR;
                            end
                            else
                            begin
                                phase_next = PH_SEEKS;
                            end
                        end
                        else
                        begin
                            phase_next = PH_SKIPAC;
                        end
                    end
                end
                PH_SKIPC, PH_SKIPAC, PH_SKIPS:
                begin
                    left_next = left_next - 32'd1;
                    if (left_next == 32'd0)
                    begin
                        idx_next = 5'd0;
                        if (pos_next == form_size_next)
                        begin
                            ev = EV_ERROR;
                            err_next = (phase_next == PH_SKIPC) ? ERR_NO_COMM : ERR_NO_SSND;
                            phase_next = PH_ERR;
                        end
                        else
                        begin
                            phase_next = (phase_next == PH_SKIPC) ? PH_SEEKC : PH_SEEKS;
                        end
                    end
                end
                PH_SSNDH:
                begin
                    if (idx == 5'd7)
                    begin
                        left_next = hi32;
                        if (hi32 == 32'd0)
                        begin
                            ev = EV_READY; bif_next = 32'd0; done_next = 32'd0;
                            phase_next = PH_DATA;
                        end
                        else
                        begin
                            phase_next = PH_OFFS;
                        end
                    end
                end
                PH_OFFS:
                begin
                    left_next = left_next - 32'd1;
                    if (left_next == 32'd0)
                    begin
                        ev = EV_READY; bif_next = 32'd0; done_next = 32'd0;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    ev       = EV_SAMPLE;
                    sb       = src_data.in_byte;
                    bif_next = bif_next + 32'd1;
                    if (bif_next >= frame_bytes_reg)
                    begin
                        bif_next  = 32'd0;
                        fe        = 1'b1;
                        done_next = done_next + 32'd1;
                        if (done_next == frames_next)
                        begin
                            ls = 1'b1; phase_next = PH_DONE;
                        end
                    end
                end
                default:
                begin
                    ev = EV_IGNORE;
                end
            endcase
        end

        res_next.event_res       = ev;
        res_next.sample_byte     = sb;
        res_next.frame_end       = fe;
        res_next.last_sample     = ls;
        res_next.error_code      = err_next;
        res_next.is_aifc         = aifc_next;
        res_next.channel_count   = chan_next;
        res_next.frame_count     = frames_next;
        res_next.bits_per_sample = size_next;
        res_next.rate_hz         = rate_next;
        res_next.total_size      = form_size_next;

        res_valid_next = accept | (res_valid_reg & res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR;
            idx_reg        <= 5'd0;
            shift_reg      <= 64'd0;
            pos_reg        <= 32'd0;
            form_size_reg  <= 32'd0;
            left_reg       <= 32'd0;
            aifc_reg       <= 1'b0;
            comm_found_reg <= 1'b0;
            chan_reg       <= 16'd0;
            frames_reg     <= 32'd0;
            size_reg       <= 16'd0;
            rate_reg       <= 64'd0;
            bif_reg        <= 32'd0;
            done_reg       <= 32'd0;
            err_reg        <= 4'd0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                phase_reg      <= phase_next;
                idx_reg        <= idx_next;
                shift_reg      <= shift_next;
                pos_reg        <= pos_next;
                form_size_reg  <= form_size_next;
                left_reg       <= left_next;
                aifc_reg       <= aifc_next;
                comm_found_reg <= comm_found_next;
                chan_reg       <= chan_next;
                frames_reg     <= frames_next;
                size_reg       <= size_next;
                rate_reg       <= rate_next;
                bif_reg        <= bif_next;
                done_reg       <= done_next;
                err_reg        <= err_next;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        // bytes per sample (ceil of size / 8) times channels
        frame_bytes_reg <= {18'd0, sample_bytes} * {16'd0, chan_reg};
        if (accept)
        begin
            res_reg <= res_next;
        end
    end
endmodule

@@ hw/rtl/ash_rate_conv.sv @@
// 80-bit extended float to signed (two's complement) 64-bit integer conversion
// depends on ash_pkg
module ash_rate_conv (
    input  logic [15:0] expw,
    input  logic [63:0] mant,
    output logic [63:0] rate
);
    import ash_pkg::*;

    logic [14:0] e;
    logic [63:0] m_signed;
    logic [14:0] amt;

    always_comb
    begin
        e        = expw[14:0];
        m_signed = expw[15] ? (64'd0 - mant) : mant;
        amt      = 15'd0;
        if ((e == EXP_SPECIAL) && (mant != 64'd0))
        begin
            rate = 64'd0;
        end
        else if (e > EXP_UNITY)
        begin
            amt  = e - EXP_UNITY;
            rate = (amt < 15'd64) ? (m_signed << amt[5:0]) : 64'd0;
        end
        else
        begin
            amt  = EXP_UNITY - e;
            rate = (amt < 15'd64) ? (m_signed >> amt[5:0]) : 64'd0;
        end
    end
endmodule

@@ hw/rtl/ash_checker.sv @@
// port level checker of the aiff stream header parser, with its bind
// depends on ash_pkg and assert_macros.svh
`include "assert_macros.svh"
module ash_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              src_valid,
    input logic              src_stall,
    input ash_pkg::ash_in_t  src_data,
    input logic              res_valid,
    input logic              res_stall,
    input ash_pkg::ash_out_t res_data
);
    import ash_pkg::*;

    `ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_data), "stalled result changed")
    `ASSERT_CLK(a_stall_cause, src_stall |-> (res_valid && res_stall), "input stalled without waiting result")
    `ASSERT_CLK(a_last_frame, res_valid && res_data.last_sample |-> res_data.frame_end && (res_data.event_res == EV_SAMPLE), "last sample without frame end")
    `ASSERT_CLK(a_err_code, res_valid && (res_data.event_res == EV_ERROR) |-> (res_data.error_code != ERR_NONE), "error event without code")
endmodule

bind aiff_stream_header_parser ash_checker u_ash_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);
